// ===== sv/ctse_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock time-setting editor: shared definitions
// Event kinds, field selector codes, the calendar record and the month
// length function used by the editor datapath.
// ----------------------------------------------------------------------------
package ctse_pkg;

  // Event kinds carried on the request side-band.
  typedef enum logic [2:0] {
    KIND_LOAD = 3'd0,
    KIND_MODE = 3'd1,
    KIND_NEXT = 3'd2,
    KIND_UP   = 3'd3,
    KIND_DOWN = 3'd4,
    KIND_TICK = 3'd5
  } kind_e;

  // Field selector, in the order the next-field key walks through.
  typedef enum logic [2:0] {
    FIELD_YEAR   = 3'd0,
    FIELD_MONTH  = 3'd1,
    FIELD_DATE   = 3'd2,
    FIELD_HOUR   = 3'd3,
    FIELD_MINUTE = 3'd4,
    FIELD_SECOND = 3'd5
  } field_e;

  localparam logic [6:0]  YEAR_MAX        = 7'd99;
  localparam logic [3:0]  MONTH_MAX       = 4'd12;
  localparam logic [4:0]  HOUR_MAX        = 5'd23;
  localparam logic [5:0]  MINUTE_MAX      = 6'd59;
  localparam logic [5:0]  SECOND_MAX      = 6'd59;
  localparam logic [15:0] BLINK_TICKS_RST = 16'd200;

  localparam int unsigned TDATA_IN_W  = 40;
  localparam int unsigned TDATA_OUT_W = 40;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } cal_t;

  typedef struct packed {
    logic   set_mode;
    field_e sel;
    logic   blink;
    cal_t   cal;
  } edit_t;

  // Days in a month; February is a leap month when the year is a multiple of 4.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] len;
    case (month)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/ctse_in_stage.sv =====
// ----------------------------------------------------------------------------
// Clock time-setting editor: input register
// Captures one request and holds it until the editor core consumes it.
// ----------------------------------------------------------------------------
module ctse_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ctse_pkg::TDATA_IN_W-1:0] s_axis_tdata,
  input  logic [2:0]                    s_axis_tuser,
  input  logic                          take_i,
  output logic                          valid_o,
  output ctse_pkg::kind_e               kind_o,
  output ctse_pkg::cal_t                load_o
);
  import ctse_pkg::*;

  logic  valid_q, valid_d;
  kind_e kind_q;
  cal_t  load_q;

  // Free slot, or the held request leaves in this cycle.
  assign s_axis_tready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q        <= kind_e'(s_axis_tuser);
      load_q.year   <= s_axis_tdata[6:0];
      load_q.month  <= s_axis_tdata[10:7];
      load_q.date   <= s_axis_tdata[15:11];
      load_q.hour   <= s_axis_tdata[20:16];
      load_q.minute <= s_axis_tdata[26:21];
      load_q.second <= s_axis_tdata[32:27];
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign load_o  = load_q;

endmodule

// ===== sv/ctse_core.sv =====
// ----------------------------------------------------------------------------
// Clock time-setting editor: editor state and update logic
// Holds the calendar, mode, selector, blink flag and tick counter, and
// applies one event per cycle when told to.
// ----------------------------------------------------------------------------
module ctse_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic            apply_i,
  input  ctse_pkg::kind_e kind_i,
  input  ctse_pkg::cal_t  load_i,
  output ctse_pkg::edit_t edit_o,
  output logic            commit_o
);
  import ctse_pkg::*;

  edit_t       edit_q, edit_d;
  logic [15:0] tick_q, tick_d, tick_inc;
  logic [15:0] blink_ticks_q;
  logic        commit;
  logic [5:0]  date_w;
  logic [4:0]  len_new, len_load;
  logic [3:0]  load_month;
  logic [6:0]  load_year;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ticks_q <= BLINK_TICKS_RST;
    end else if (cfg_we_i) begin
      blink_ticks_q <= cfg_wdata_i;
    end
  end

  // Repaired year and month of a load, used to check the loaded day.
  assign load_year  = (load_i.year > YEAR_MAX) ? 7'd0 : load_i.year;
  assign load_month = (load_i.month == 4'd0 || load_i.month > MONTH_MAX) ? 4'd1 : load_i.month;
  assign len_load   = month_len(load_month, load_year);
  assign tick_inc   = tick_q + 16'd1;

  always_comb begin
    edit_d  = edit_q;
    tick_d  = tick_q;
    commit  = 1'b0;
    date_w  = {1'b0, edit_q.cal.date};
    len_new = 5'd31;
    case (kind_i)
      KIND_LOAD: begin
        edit_d.cal.year   = load_year;
        edit_d.cal.month  = load_month;
        edit_d.cal.date   = (load_i.date == 5'd0 || load_i.date > len_load) ? 5'd1 : load_i.date;
        edit_d.cal.hour   = (load_i.hour > HOUR_MAX) ? 5'd0 : load_i.hour;
        edit_d.cal.minute = (load_i.minute > MINUTE_MAX) ? 6'd0 : load_i.minute;
        edit_d.cal.second = (load_i.second > SECOND_MAX) ? 6'd0 : load_i.second;
      end
      KIND_MODE: begin
        if (!edit_q.set_mode) begin
          edit_d.set_mode = 1'b1;
          edit_d.sel      = FIELD_YEAR;
        end else begin
          edit_d.set_mode = 1'b0;
          commit          = 1'b1;
        end
      end
      KIND_NEXT: begin
        if (edit_q.set_mode) begin
          edit_d.sel = (edit_q.sel >= FIELD_SECOND) ? FIELD_YEAR : field_e'(edit_q.sel + 3'd1);
        end
      end
      KIND_UP: begin
        if (edit_q.set_mode) begin
          case (edit_q.sel)
            FIELD_YEAR: begin
              edit_d.cal.year = (edit_q.cal.year >= YEAR_MAX) ? 7'd0 : edit_q.cal.year + 7'd1;
            end
            FIELD_MONTH: begin
              edit_d.cal.month = (edit_q.cal.month >= MONTH_MAX) ? 4'd1
                                                                 : edit_q.cal.month + 4'd1;
            end
            FIELD_DATE: begin
              date_w = {1'b0, edit_q.cal.date} + 6'd1;
            end
            FIELD_HOUR: begin
              edit_d.cal.hour = (edit_q.cal.hour >= HOUR_MAX) ? 5'd0 : edit_q.cal.hour + 5'd1;
            end
            FIELD_MINUTE: begin
              edit_d.cal.minute = (edit_q.cal.minute >= MINUTE_MAX) ? 6'd0
                                                                    : edit_q.cal.minute + 6'd1;
            end
            default: begin
              edit_d.cal.second = (edit_q.cal.second >= SECOND_MAX) ? 6'd0
                                                                    : edit_q.cal.second + 6'd1;
            end
          endcase
          len_new = month_len(edit_d.cal.month, edit_d.cal.year);
          if (date_w > {1'b0, len_new}) begin
            date_w = 6'd1;
          end
          edit_d.cal.date = date_w[4:0];
        end
      end
      KIND_DOWN: begin
        if (edit_q.set_mode) begin
          case (edit_q.sel)
            FIELD_YEAR: begin
              edit_d.cal.year = (edit_q.cal.year == 7'd0) ? YEAR_MAX : edit_q.cal.year - 7'd1;
            end
            FIELD_MONTH: begin
              edit_d.cal.month = (edit_q.cal.month <= 4'd1) ? MONTH_MAX
                                                            : edit_q.cal.month - 4'd1;
            end
            FIELD_DATE: begin
              date_w = (edit_q.cal.date == 5'd0) ? 6'd0 : {1'b0, edit_q.cal.date} - 6'd1;
            end
            FIELD_HOUR: begin
              edit_d.cal.hour = (edit_q.cal.hour == 5'd0) ? HOUR_MAX : edit_q.cal.hour - 5'd1;
            end
            FIELD_MINUTE: begin
              edit_d.cal.minute = (edit_q.cal.minute == 6'd0) ? MINUTE_MAX
                                                              : edit_q.cal.minute - 6'd1;
            end
            default: begin
              edit_d.cal.second = (edit_q.cal.second == 6'd0) ? SECOND_MAX
                                                              : edit_q.cal.second - 6'd1;
            end
          endcase
          len_new = month_len(edit_d.cal.month, edit_d.cal.year);
          // A day stepped below one wraps to the month's last day.
          if (date_w == 6'd0) begin
            date_w = {1'b0, len_new};
          end
          if (date_w > {1'b0, len_new}) begin
            date_w = 6'd1;
          end
          edit_d.cal.date = date_w[4:0];
        end
      end
      KIND_TICK: begin
        if (tick_inc >= blink_ticks_q) begin
          tick_d       = 16'd0;
          edit_d.blink = !edit_q.blink;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edit_q.set_mode   <= 1'b0;
      edit_q.sel        <= FIELD_YEAR;
      edit_q.blink      <= 1'b0;
      edit_q.cal.year   <= 7'd0;
      edit_q.cal.month  <= 4'd1;
      edit_q.cal.date   <= 5'd1;
      edit_q.cal.hour   <= 5'd0;
      edit_q.cal.minute <= 6'd0;
      edit_q.cal.second <= 6'd0;
      tick_q            <= 16'd0;
    end else if (apply_i) begin
      edit_q <= edit_d;
      tick_q <= tick_d;
    end
  end

  assign edit_o   = edit_d;
  assign commit_o = commit;

endmodule

// ===== sv/clock_time_setting_editor_unit.sv =====
// ----------------------------------------------------------------------------
// Clock time-setting editor
// Button-driven editor for a calendar clock with set mode, field selection,
// wrapping up and down keys and a blinking selected field.
// ----------------------------------------------------------------------------
// Use of the block:
// Each request on the slave stream is one event. Its kind travels in
// s_axis_tuser (load time, mode key, next-field key, up, down, tick) and the
// time to load travels in s_axis_tdata; the load fields are ignored for the
// other kinds. Every request gives exactly one result on the master stream:
// the editor state after the event together with a commit flag that is high
// only on the mode key that leaves set mode.
// The request is first held in the input register; its result is written
// into the result register once that register is free or being emptied, and
// is offered on the master stream from there. The update is a single pass of
// short logic on the held state, so one request is taken every cycle while
// the receiver does not stall.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more; only then does s_axis_tready fall.
// Reset clears the pipeline, leaves display mode, selects the year, clears the
// blink flag and tick counter and sets the time to year 0, 1 January, 00:00:00.
// The blink period register returns to 200 ticks. The user writes it through
// cfg_we_i / cfg_wdata_i only while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
module clock_time_setting_editor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Blink period in ticks.
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] load_year, [10:7] load_month, [15:11] load_date, [20:16] load_hour,
  // [26:21] load_minute, [32:27] load_second, [39:33] zero.
  input  logic [ctse_pkg::TDATA_IN_W-1:0] s_axis_tdata,
  // [2:0] kind.
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] in_set_mode, [3:1] selected_field, [4] blank_selected, [11:5] year,
  // [15:12] month, [20:16] day_of_month, [25:21] hour, [31:26] minute,
  // [37:32] second, [38] commit, [39] zero.
  output logic [ctse_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
  import ctse_pkg::*;

  logic  in_valid;
  kind_e in_kind;
  cal_t  in_load;
  logic  apply;
  edit_t edit_next;
  logic  commit_next;

  logic  out_valid_q, out_valid_d;
  edit_t out_edit_q;
  logic  out_commit_q;

  ctse_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (apply),
    .valid_o       (in_valid),
    .kind_o        (in_kind),
    .load_o        (in_load)
  );

  // The held request is applied when the result register is free or is
  // being emptied in this cycle.
  assign apply = in_valid && (!out_valid_q || m_axis_tready);

  ctse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .apply_i     (apply),
    .kind_i      (in_kind),
    .load_i      (in_load),
    .edit_o      (edit_next),
    .commit_o    (commit_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (apply) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply) begin
      out_edit_q   <= edit_next;
      out_commit_q <= commit_next;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_commit_q,
                          out_edit_q.cal.second,
                          out_edit_q.cal.minute,
                          out_edit_q.cal.hour,
                          out_edit_q.cal.date,
                          out_edit_q.cal.month,
                          out_edit_q.cal.year,
                          out_edit_q.blink,
                          out_edit_q.sel,
                          out_edit_q.set_mode};

endmodule
